// ----- rtl/core/rbr_pkg.sv -----
// Shared constants, types and codes of the bilinear RGB resizer.
package rbr_pkg;

	localparam int SRC_W_MAX = 256;
	localparam int SRC_H_MAX = 256;
	localparam int DST_MAX   = 4096;
	localparam int FRAC      = 16;

	localparam int CH    = 8;
	localparam int NCH   = 3;
	localparam int RGBW  = CH * NCH;
	localparam int COLW  = 12;
	localparam int SWW   = 9;
	localparam int TWW   = 13;
	localparam int CFGW  = 13;
	localparam int CFGIW = 2;

	localparam int XW   = $clog2(SRC_W_MAX);
	localparam int YW   = $clog2(SRC_H_MAX);
	localparam int MW   = (XW > YW) ? XW : YW;
	localparam int DW   = $clog2(DST_MAX);
	localparam int PW   = DW + MW;
	localparam int NDIV = MW + FRAC;

	localparam int BANK_DEPTH = SRC_W_MAX * SRC_H_MAX / 4;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam int HW = CH + FRAC + 1;
	localparam int TW = CH + FRAC;
	localparam int VW = CH + 2 * FRAC + 1;
	localparam int RW = VW - 2 * FRAC;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_REQ  = 1'b1
	} op_t;

	typedef enum logic [CFGIW-1:0] {
		CFG_SRC_W = 2'd0,
		CFG_SRC_H = 2'd1,
		CFG_DST_W = 2'd2,
		CFG_DST_H = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [XW-1:0] sw_m1;
		logic [YW-1:0] sh_m1;
		logic [DW-1:0] tw_m1;
		logic [DW-1:0] th_m1;
		logic [DW-1:0] div_x;
		logic [DW-1:0] div_y;
	} geom_t;

	typedef struct packed {
		op_t             op;
		logic [PW-1:0]   prod_x;
		logic [PW-1:0]   prod_y;
		logic [XW-1:0]   wcol;
		logic [YW-1:0]   wrow;
		logic [RGBW-1:0] rgb;
	} item_t;

endpackage

// ----- rtl/core/bilinear_rgb_resizer_top.sv -----
// Top level of the bilinear RGB resizer: config registers, front, queue, back.
//
// Usage: the item channel (item_valid/item_stall) takes loads (mode 0),
// which write one RGB pixel into the 256x256 frame store, and requests
// (mode 1), which ask for one destination pixel of the target image.
// The result channel (result_valid/result_stall) returns one RGB pixel
// per request, in order; loads give no result and loads outside the
// source size are dropped. Sizes are written over cfg_we/cfg_index/cfg_data
// while no item is in flight: a rule for the user, not enforced.
// Throughput: one item per cycle while item_stall is low. From item accept
// to result valid an item passes the front register, the queue, a 24-stage
// restoring divider (one quotient bit per stage for each axis), the frame
// store read in four parity banks, and three multiply/round stages.
// When the receiver stalls, the whole back pipeline holds; the queue then
// fills and item_stall rises. Reset clears all control state; the frame
// store is not cleared and must be loaded before it is read.
module bilinear_rgb_resizer_top import rbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             mode,
	input  logic [COLW-1:0]  col,
	input  logic [COLW-1:0]  row,
	input  logic [CH-1:0]    red_in,
	input  logic [CH-1:0]    green_in,
	input  logic [CH-1:0]    blue_in,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [CH-1:0]    red_out,
	output logic [CH-1:0]    green_out,
	output logic [CH-1:0]    blue_out,
	input  logic             cfg_we,
	input  logic [CFGIW-1:0] cfg_index,
	input  logic [CFGW-1:0]  cfg_data
);

	logic [SWW-1:0] src_w_q, src_h_q;
	logic [TWW-1:0] dst_w_q, dst_h_q;
	logic [SWW-1:0] sw_c, sh_c;
	logic [TWW-1:0] tw_c, th_c;
	geom_t          geom;
	logic           push, pop, head_valid;
	item_t          push_item, head;
	logic [QAW:0]   q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SWW'(256);
			src_h_q <= SWW'(256);
			dst_w_q <= TWW'(256);
			dst_h_q <= TWW'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_W: src_w_q <= cfg_data[SWW-1:0];
				CFG_SRC_H: src_h_q <= cfg_data[SWW-1:0];
				CFG_DST_W: dst_w_q <= cfg_data[TWW-1:0];
				CFG_DST_H: dst_h_q <= cfg_data[TWW-1:0];
			endcase
		end
	end

	always_comb begin
		sw_c = (src_w_q == '0) ? SWW'(1) :
			(32'(src_w_q) > SRC_W_MAX) ? SWW'(SRC_W_MAX) : src_w_q;
		sh_c = (src_h_q == '0) ? SWW'(1) :
			(32'(src_h_q) > SRC_H_MAX) ? SWW'(SRC_H_MAX) : src_h_q;
		tw_c = (dst_w_q == '0) ? TWW'(1) :
			(32'(dst_w_q) > DST_MAX) ? TWW'(DST_MAX) : dst_w_q;
		th_c = (dst_h_q == '0) ? TWW'(1) :
			(32'(dst_h_q) > DST_MAX) ? TWW'(DST_MAX) : dst_h_q;
		geom.sw_m1 = XW'(sw_c - 1'b1);
		geom.sh_m1 = YW'(sh_c - 1'b1);
		geom.tw_m1 = DW'(tw_c - 1'b1);
		geom.th_m1 = DW'(th_c - 1'b1);
		geom.div_x = (geom.tw_m1 == '0) ? DW'(1) : geom.tw_m1;
		geom.div_y = (geom.th_m1 == '0) ? DW'(1) : geom.th_m1;
	end

	rbr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.col        (col),
		.row        (row),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.geom       (geom),
		.q_count    (q_count),
		.push       (push),
		.push_item  (push_item)
	);

	rbr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	rbr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out)
	);

endmodule

// ----- rtl/core/rbr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/rbr_front.sv -----
// Front end: accepts items, drops out-of-range loads, forms the axis products.
module rbr_front import rbr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic            mode,
	input  logic [COLW-1:0] col,
	input  logic [COLW-1:0] row,
	input  logic [CH-1:0]   red_in,
	input  logic [CH-1:0]   green_in,
	input  logic [CH-1:0]   blue_in,
	input  geom_t           geom,
	input  logic [QAW:0]    q_count,
	output logic            push,
	output item_t           push_item
);

	logic          s1_valid_q;
	item_t         s1_item_q;
	item_t         nxt;
	logic          accept;
	logic          keep;
	logic [DW-1:0] dcol;
	logic [DW-1:0] drow;

	assign item_stall = (32'(q_count) + 32'(s1_valid_q)) >= QDEPTH;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		dcol = (32'(col) > 32'(geom.tw_m1)) ? geom.tw_m1 : DW'(col);
		drow = (32'(row) > 32'(geom.th_m1)) ? geom.th_m1 : DW'(row);
		nxt.op     = op_t'(mode);
		nxt.prod_x = PW'(dcol) * PW'(geom.sw_m1);
		nxt.prod_y = PW'(drow) * PW'(geom.sh_m1);
		nxt.wcol   = XW'(col);
		nxt.wrow   = YW'(row);
		nxt.rgb    = {red_in, green_in, blue_in};
		keep = (nxt.op == OP_REQ) ||
			((32'(col) <= 32'(geom.sw_m1)) && (32'(row) <= 32'(geom.sh_m1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_q <= nxt;
		end
	end

	assign push      = s1_valid_q;
	assign push_item = s1_item_q;

endmodule

// ----- rtl/core/rbr_queue.sv -----
// Short item queue between the front end and the back end.
module rbr_queue import rbr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  item_t        push_item,
	input  logic         pop,
	output logic         head_valid,
	output item_t        head,
	output logic [QAW:0] count
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (32'(count_q) < QDEPTH))
		else $error("queue overflow");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty count");

endmodule

// ----- rtl/core/rbr_back.sv -----
// Back end: pipelined position divider, banked frame store, bilinear blend.
module rbr_back import rbr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  geom_t         geom,
	input  logic          head_valid,
	input  item_t         head,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [CH-1:0] red_out,
	output logic [CH-1:0] green_out,
	output logic [CH-1:0] blue_out
);

	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic b,
		input logic [DW-1:0] dv);
		logic [DW:0] t;
		t = {rem, b};
		if (t >= {1'b0, dv}) begin
			div_step = {1'b1, DW'(t - {1'b0, dv})};
		end else begin
			div_step = {1'b0, t[DW-1:0]};
		end
	endfunction

	logic adv;

	// divider stages
	logic            dv_valid_sd [0:NDIV];
	op_t             dv_op_sd    [0:NDIV];
	logic [DW-1:0]   dv_rx_sd    [0:NDIV];
	logic [DW-1:0]   dv_ry_sd    [0:NDIV];
	logic [MW-1:0]   dv_lx_sd    [0:NDIV];
	logic [MW-1:0]   dv_ly_sd    [0:NDIV];
	logic [NDIV-1:0] dv_qx_sd    [0:NDIV];
	logic [NDIV-1:0] dv_qy_sd    [0:NDIV];
	logic [XW-1:0]   dv_wcol_sd  [0:NDIV];
	logic [YW-1:0]   dv_wrow_sd  [0:NDIV];
	logic [RGBW-1:0] dv_rgb_sd   [0:NDIV];
	logic [DW:0]     stx         [NDIV];
	logic [DW:0]     sty         [NDIV];

	// address stage
	logic            s1_valid;
	op_t             s1_op;
	logic [XW-1:0]   s1_x0, s1_x1;
	logic [YW-1:0]   s1_y0, s1_y1;
	logic [FRAC-1:0] s1_fx, s1_fy;
	logic [XW-1:0]   s1_wcol;
	logic [YW-1:0]   s1_wrow;
	logic [RGBW-1:0] s1_rgb;
	logic [MW-1:0]   hix, hiy;
	logic [XW-1:0]   x0n, x1n;
	logic [YW-1:0]   y0n, y1n;

	// read-data stage
	logic            s2_valid;
	op_t             s2_op;
	logic            s2_x0b, s2_x1b, s2_y0b, s2_y1b;
	logic [FRAC-1:0] s2_fx, s2_fy;
	logic [RGBW-1:0] bank_rd [4];
	logic [3:0]      bank_we, bank_re;
	logic [RGBW-1:0] p00, p10, p01, p11;
	logic [FRAC:0]   wx0, wy0;

	// horizontal products
	logic            s3_valid;
	op_t             s3_op;
	logic [FRAC-1:0] s3_fy;
	logic [HW-1:0]   s3_ha [NCH];
	logic [HW-1:0]   s3_hb [NCH];
	logic [HW-1:0]   s3_hd [NCH];
	logic [HW-1:0]   s3_he [NCH];

	// vertical products
	logic            s4_valid;
	op_t             s4_op;
	logic [VW-1:0]   s4_vt [NCH];
	logic [VW-1:0]   s4_vb [NCH];

	logic            res_valid_q;
	logic [RGBW-1:0] res_rgb_q;
	logic [RGBW-1:0] rgb_n;

	assign adv = !res_valid_q || !result_stall;
	assign pop = adv && head_valid;

	always_comb begin
		for (int k = 0; k < NDIV; k++) begin
			stx[k] = div_step(dv_rx_sd[k], dv_lx_sd[k][MW-1], geom.div_x);
			sty[k] = div_step(dv_ry_sd[k], dv_ly_sd[k][MW-1], geom.div_y);
		end
	end

	always_comb begin
		hix = dv_qx_sd[NDIV][NDIV-1:FRAC];
		hiy = dv_qy_sd[NDIV][NDIV-1:FRAC];
		x0n = (hix > MW'(geom.sw_m1)) ? geom.sw_m1 : XW'(hix);
		y0n = (hiy > MW'(geom.sh_m1)) ? geom.sh_m1 : YW'(hiy);
		x1n = (x0n == geom.sw_m1) ? x0n : x0n + 1'b1;
		y1n = (y0n == geom.sh_m1) ? y0n : y0n + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NDIV; k++) begin
				dv_valid_sd[k] <= 1'b0;
			end
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			s3_valid    <= 1'b0;
			s4_valid    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			dv_valid_sd[0] <= head_valid;
			for (int k = 0; k < NDIV; k++) begin
				dv_valid_sd[k+1] <= dv_valid_sd[k];
			end
			s1_valid    <= dv_valid_sd[NDIV];
			s2_valid    <= s1_valid;
			s3_valid    <= s2_valid;
			s4_valid    <= s3_valid;
			res_valid_q <= s4_valid && (s4_op == OP_REQ);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_op_sd[0]   <= head.op;
			dv_rx_sd[0]   <= head.prod_x[PW-1:MW];
			dv_ry_sd[0]   <= head.prod_y[PW-1:MW];
			dv_lx_sd[0]   <= head.prod_x[MW-1:0];
			dv_ly_sd[0]   <= head.prod_y[MW-1:0];
			dv_qx_sd[0]   <= '0;
			dv_qy_sd[0]   <= '0;
			dv_wcol_sd[0] <= head.wcol;
			dv_wrow_sd[0] <= head.wrow;
			dv_rgb_sd[0]  <= head.rgb;
			for (int k = 0; k < NDIV; k++) begin
				dv_op_sd[k+1]   <= dv_op_sd[k];
				dv_rx_sd[k+1]   <= stx[k][DW-1:0];
				dv_ry_sd[k+1]   <= sty[k][DW-1:0];
				dv_lx_sd[k+1]   <= {dv_lx_sd[k][MW-2:0], 1'b0};
				dv_ly_sd[k+1]   <= {dv_ly_sd[k][MW-2:0], 1'b0};
				dv_qx_sd[k+1]   <= {dv_qx_sd[k][NDIV-2:0], stx[k][DW]};
				dv_qy_sd[k+1]   <= {dv_qy_sd[k][NDIV-2:0], sty[k][DW]};
				dv_wcol_sd[k+1] <= dv_wcol_sd[k];
				dv_wrow_sd[k+1] <= dv_wrow_sd[k];
				dv_rgb_sd[k+1]  <= dv_rgb_sd[k];
			end

			s1_op   <= dv_op_sd[NDIV];
			s1_x0   <= x0n;
			s1_x1   <= x1n;
			s1_y0   <= y0n;
			s1_y1   <= y1n;
			s1_fx   <= dv_qx_sd[NDIV][FRAC-1:0];
			s1_fy   <= dv_qy_sd[NDIV][FRAC-1:0];
			s1_wcol <= dv_wcol_sd[NDIV];
			s1_wrow <= dv_wrow_sd[NDIV];
			s1_rgb  <= dv_rgb_sd[NDIV];

			s2_op  <= s1_op;
			s2_x0b <= s1_x0[0];
			s2_x1b <= s1_x1[0];
			s2_y0b <= s1_y0[0];
			s2_y1b <= s1_y1[0];
			s2_fx  <= s1_fx;
			s2_fy  <= s1_fy;

			s3_op <= s2_op;
			s3_fy <= s2_fy;
			for (int c = 0; c < NCH; c++) begin
				s3_ha[c] <= HW'(p00[c*CH +: CH]) * HW'(wx0);
				s3_hb[c] <= HW'(p10[c*CH +: CH]) * HW'(s2_fx);
				s3_hd[c] <= HW'(p01[c*CH +: CH]) * HW'(wx0);
				s3_he[c] <= HW'(p11[c*CH +: CH]) * HW'(s2_fx);
			end

			s4_op <= s3_op;
			for (int c = 0; c < NCH; c++) begin
				s4_vt[c] <= VW'(TW'(s3_ha[c] + s3_hb[c])) * VW'(wy0);
				s4_vb[c] <= VW'(TW'(s3_hd[c] + s3_he[c])) * VW'(s3_fy);
			end

			res_rgb_q <= rgb_n;
		end
	end

	// four banks split by column and row parity
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [XW-1:0] xsel;
		logic [YW-1:0] ysel;
		assign xsel = (s1_x0[0] == 1'(b % 2)) ? s1_x0 : s1_x1;
		assign ysel = (s1_y0[0] == 1'(b / 2)) ? s1_y0 : s1_y1;
		assign bank_we[b] = adv && s1_valid && (s1_op == OP_LOAD) &&
			(s1_wcol[0] == 1'(b % 2)) && (s1_wrow[0] == 1'(b / 2));
		assign bank_re[b] = adv && s1_valid && (s1_op == OP_REQ);

		rbr_ram #(
			.WIDTH(RGBW),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr ({s1_wrow[YW-1:1], s1_wcol[XW-1:1]}),
			.wdata (s1_rgb),
			.re    (bank_re[b]),
			.raddr ({ysel[YW-1:1], xsel[XW-1:1]}),
			.rdata (bank_rd[b])
		);
	end

	always_comb begin
		p00 = bank_rd[{s2_y0b, s2_x0b}];
		p10 = bank_rd[{s2_y0b, s2_x1b}];
		p01 = bank_rd[{s2_y1b, s2_x0b}];
		p11 = bank_rd[{s2_y1b, s2_x1b}];
		wx0 = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(s2_fx);
		wy0 = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(s3_fy);
	end

	always_comb begin
		logic [VW-1:0] v;
		logic [RW-1:0] r;
		rgb_n = '0;
		for (int c = 0; c < NCH; c++) begin
			v = s4_vt[c] + s4_vb[c] + (VW'(1) << (2 * FRAC - 1));
			r = v[VW-1:2*FRAC];
			rgb_n[c*CH +: CH] = (r > RW'((1 << CH) - 1)) ? CH'((1 << CH) - 1) : CH'(r);
		end
	end

	assign result_valid = res_valid_q;
	assign red_out      = res_rgb_q[3*CH-1:2*CH];
	assign green_out    = res_rgb_q[2*CH-1:CH];
	assign blue_out     = res_rgb_q[CH-1:0];

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we))
		else $error("more than one bank written");
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(|(bank_we & bank_re)))
		else $error("bank read and written together");
	a_nbr_step: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> ((s1_x1 == s1_x0 || s1_x1 == s1_x0 + 1'b1) &&
			(s1_y1 == s1_y0 || s1_y1 == s1_y0 + 1'b1)))
		else $error("neighbor index not adjacent");

endmodule
